>>> rtl/core/hsv2rgb_pkg.sv
// Package for the HSV to RGB converter: field widths, register indexes,
// sector codes and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    // Field and register widths
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int LEVEL_W = 8;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE      = 1'd1;

    // Register reset values
    localparam logic [PCT_W-1:0] SAT_RESET = 7'd80;
    localparam logic [PCT_W-1:0] VAL_RESET = 7'd100;
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;

    // Hue split: sector = hue / 60 by reciprocal, offset = hue % 60
    localparam int SECT_W   = 4;
    localparam int OFFS_W   = 6;
    localparam int HUE_RECIP_W     = 11;
    localparam int HUE_RECIP_SHIFT = 16;
    localparam logic [HUE_RECIP_W-1:0] HUE_RECIP = 11'd1093;
    localparam logic [5:0] DEG_PER_SECTOR = 6'd60;

    // Sector codes; every other code takes the sector-five choice
    localparam logic [SECT_W-1:0] SECT_RED_UP    = 4'd0;
    localparam logic [SECT_W-1:0] SECT_RED_DOWN  = 4'd1;
    localparam logic [SECT_W-1:0] SECT_BLUE_UP   = 4'd2;
    localparam logic [SECT_W-1:0] SECT_GREEN_DN  = 4'd3;
    localparam logic [SECT_W-1:0] SECT_RED_RISE  = 4'd4;

    // Numerators over the common denominator 600000
    localparam int PROD_W = 14;   // V*S and V*(100-S), at most 10000
    localparam int NUM_W  = 20;   // channel numerators, at most 600000
    localparam logic [12:0] HI_SCALE = 13'd6000;
    localparam logic [5:0]  LO_SCALE = 6'd60;

    // Level = floor((n*17 + 20000) / 40000) = floor(((n*17 + 20000) >> 6) / 625)
    localparam int SCALED_W = 24;
    localparam int SCALED_SHIFT = 6;
    localparam int QUOT_IN_W = SCALED_W - SCALED_SHIFT;   // 18 bits
    localparam logic [4:0]  LEVEL_MUL  = 5'd17;
    localparam logic [14:0] LEVEL_BIAS = 15'd20000;
    localparam int LVL_RECIP_W     = 19;
    localparam int LVL_RECIP_SHIFT = 28;
    localparam logic [LVL_RECIP_W-1:0] LVL_RECIP = 19'd429497;   // ceil(2^28 / 625)
    localparam int LVL_PROD_W = QUOT_IN_W + LVL_RECIP_W;
    localparam int LVL_Q_W    = LVL_PROD_W - LVL_RECIP_SHIFT;   // 9 bits
    localparam logic [LVL_Q_W-1:0] LEVEL_MAX = 9'd255;

    // Bundle of the three channel values
    typedef struct packed {
        logic [NUM_W-1:0] red;
        logic [NUM_W-1:0] green;
        logic [NUM_W-1:0] blue;
    } rgb_num_t;

    typedef struct packed {
        logic [QUOT_IN_W-1:0] red;
        logic [QUOT_IN_W-1:0] green;
        logic [QUOT_IN_W-1:0] blue;
    } rgb_scaled_t;

endpackage

>>> rtl/core/hsv_to_rgb_converter_top.sv
// HSV to RGB converter, five-stage pipeline, one word per clock.
// Depends on hsv2rgb_pkg for widths, codes and fixed-point constants.
//
//   channel   signals                                  direction
//   --------  ---------------------------------------  ---------
//   input     in_valid, in_ready, hue_deg              in
//   output    out_valid, out_ready, red_level,         out
//             green_level, blue_level
//   config    cfg_we, cfg_index, cfg_data              in
//
// A word passes the stage registers in order to the output register; one word enters per
// clock while the output is taken. All five stages advance together, held
// only when the output register is full and not taken. Reset clears the
// stage valid bits and loads saturation 80 and value 100.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]     hue_deg,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hsv2rgb_pkg::LEVEL_W-1:0]   red_level,
    output logic [hsv2rgb_pkg::LEVEL_W-1:0]   green_level,
    output logic [hsv2rgb_pkg::LEVEL_W-1:0]   blue_level,
    input  logic                              cfg_we,
    input  logic [hsv2rgb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hsv2rgb_pkg::PCT_W-1:0]     cfg_data
);
    import hsv2rgb_pkg::*;

    // Configuration registers and clamped percentages
    logic [PCT_W-1:0] sat_reg;
    logic [PCT_W-1:0] val_reg;
    logic [PCT_W-1:0] sat_clamp;
    logic [PCT_W-1:0] val_clamp;

    // Pipeline control
    logic       advance;
    logic [4:0] valid_reg;

    // Stage 1: hue split and percentage products
    logic [HUE_W+HUE_RECIP_W-1:0] hue_prod;
    logic [SECT_W-1:0]  sect_next;
    logic [HUE_W-1:0]   sect_deg;
    logic [HUE_W-1:0]   offs_full;
    logic [SECT_W-1:0]  s1_sect_reg;
    logic [OFFS_W-1:0]  s1_offs_reg;
    logic [PROD_W-1:0]  s1_vs_reg;
    logic [PROD_W-1:0]  s1_vm_reg;
    logic [PCT_W-1:0]   s1_v_reg;

    // Stage 2: max, min and ramp numerators
    logic [SECT_W-1:0]  s2_sect_reg;
    logic [NUM_W-1:0]   s2_hi_reg;
    logic [NUM_W-1:0]   s2_lo_reg;
    logic [NUM_W-1:0]   s2_ramp_reg;

    // Stage 3: channel numerators
    logic [NUM_W-1:0]   rise;
    logic [NUM_W-1:0]   fall;
    rgb_num_t           num_next;
    rgb_num_t           s3_num_reg;

    // Stage 4: scaled numerators
    rgb_scaled_t        scaled_next;
    rgb_scaled_t        s4_scaled_reg;

    // Stage 5: output levels
    logic [LEVEL_W-1:0] red_reg;
    logic [LEVEL_W-1:0] green_reg;
    logic [LEVEL_W-1:0] blue_reg;
    logic [LEVEL_W-1:0] red_next;
    logic [LEVEL_W-1:0] green_next;
    logic [LEVEL_W-1:0] blue_next;

    // Divide a scaled numerator by 625 and saturate to 8 bits
    function automatic logic [LEVEL_W-1:0] to_level(input logic [QUOT_IN_W-1:0] m);
        logic [LVL_PROD_W-1:0] prod;
        logic [LVL_Q_W-1:0]    q;
        prod = LVL_PROD_W'(m) * LVL_PROD_W'(LVL_RECIP);
        q    = prod[LVL_PROD_W-1:LVL_RECIP_SHIFT];
        return (q > LEVEL_MAX) ? LEVEL_MAX[LEVEL_W-1:0] : q[LEVEL_W-1:0];
    endfunction

    // Scale a numerator: (n*17 + 20000) >> 6
    function automatic logic [QUOT_IN_W-1:0] scale_num(input logic [NUM_W-1:0] n);
        logic [SCALED_W-1:0] t;
        t = SCALED_W'(n) * SCALED_W'(LEVEL_MUL) + SCALED_W'(LEVEL_BIAS);
        return t[SCALED_W-1:SCALED_SHIFT];
    endfunction

    // Write configuration registers; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= SAT_RESET;
            val_reg <= VAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SATURATION: sat_reg <= cfg_data;
                REG_VALUE:      val_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign sat_clamp = (sat_reg > PCT_FULL) ? PCT_FULL : sat_reg;
    assign val_clamp = (val_reg > PCT_FULL) ? PCT_FULL : val_reg;

    // Advance all stages unless the output word is held
    assign advance   = !valid_reg[4] || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // Split hue into sector and offset by reciprocal multiply
    always_comb
    begin
        hue_prod  = (HUE_W+HUE_RECIP_W)'(hue_deg) * (HUE_W+HUE_RECIP_W)'(HUE_RECIP);
        sect_next = hue_prod[HUE_RECIP_SHIFT +: SECT_W];
        sect_deg  = HUE_W'(sect_next) * HUE_W'(DEG_PER_SECTOR);
        offs_full = hue_deg - sect_deg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sect_reg <= sect_next;
            s1_offs_reg <= offs_full[OFFS_W-1:0];
            s1_vs_reg   <= PROD_W'(val_clamp) * PROD_W'(sat_clamp);
            s1_vm_reg   <= PROD_W'(val_clamp) * PROD_W'(PCT_FULL - sat_clamp);
            s1_v_reg    <= val_clamp;
        end
    end

    // Form max, min and ramp over the common denominator
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_sect_reg <= s1_sect_reg;
            s2_hi_reg   <= NUM_W'(s1_v_reg) * NUM_W'(HI_SCALE);
            s2_lo_reg   <= NUM_W'(s1_vm_reg) * NUM_W'(LO_SCALE);
            s2_ramp_reg <= NUM_W'(s1_vs_reg) * NUM_W'(s1_offs_reg);
        end
    end

    // Pick channels by sector; sector five and beyond share one choice
    always_comb
    begin
        rise = s2_lo_reg + s2_ramp_reg;
        fall = s2_hi_reg - s2_ramp_reg;
        case (s2_sect_reg)
            SECT_RED_UP:
            begin
                num_next.red   = s2_hi_reg;
                num_next.green = rise;
                num_next.blue  = s2_lo_reg;
            end
            SECT_RED_DOWN:
            begin
                num_next.red   = fall;
                num_next.green = s2_hi_reg;
                num_next.blue  = s2_lo_reg;
            end
            SECT_BLUE_UP:
            begin
                num_next.red   = s2_lo_reg;
                num_next.green = s2_hi_reg;
                num_next.blue  = rise;
            end
            SECT_GREEN_DN:
            begin
                num_next.red   = s2_lo_reg;
                num_next.green = fall;
                num_next.blue  = s2_hi_reg;
            end
            SECT_RED_RISE:
            begin
                num_next.red   = rise;
                num_next.green = s2_lo_reg;
                num_next.blue  = s2_hi_reg;
            end
            default:
            begin
                num_next.red   = s2_hi_reg;
                num_next.green = s2_lo_reg;
                num_next.blue  = fall;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_num_reg <= num_next;
        end
    end

    // Fold in the 255 scale, the half-step bias and the factor of 64
    always_comb
    begin
        scaled_next.red   = scale_num(s3_num_reg.red);
        scaled_next.green = scale_num(s3_num_reg.green);
        scaled_next.blue  = scale_num(s3_num_reg.blue);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s4_scaled_reg <= scaled_next;
        end
    end

    // Divide by 625 and hold the output word
    always_comb
    begin
        red_next   = to_level(s4_scaled_reg.red);
        green_next = to_level(s4_scaled_reg.green);
        blue_next  = to_level(s4_scaled_reg.blue);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;

endmodule
